FILE: hw/rtl/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_OPC   = 2'd1,
    ST_UNMASKED  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  // One result as handed from the parser to the output side.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [3:0] opcode;
    logic       fin;
    status_e    status;
  } result_t;

  localparam logic [3:0] OPC_DATA_MAX = 4'h3;
  localparam logic [3:0] OPC_CTRL_MIN = 4'h8;
  localparam logic [3:0] OPC_CTRL_MAX = 4'hB;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length bytes still due, minus one.
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;

  function automatic logic opcode_ok(input logic [3:0] op);
    return (op <= OPC_DATA_MAX) || ((op >= OPC_CTRL_MIN) && (op <= OPC_CTRL_MAX));
  endfunction

endpackage

FILE: hw/rtl/wsd_front.sv
`timescale 1ns / 1ps

module wsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             buffer_last_i,
  output logic             push_o,
  output wsd_pkg::result_t push_data_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      opcode_q, opcode_d;
  logic            fin_q, fin_d;
  logic [63:0]     len_q, len_d;
  logic [2:0]      ext_q, ext_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      pos_q, pos_d;
  logic [7:0]      key_byte;

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    fin_d       = fin_q;
    len_d       = len_q;
    ext_d       = ext_q;
    key_d       = key_q;
    pos_d       = pos_q;
    push_o      = 1'b0;
    push_data_o = '0;

    if (accept_i) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR0: begin
          fin_d    = in_byte_i[7];
          opcode_d = in_byte_i[3:0];
          len_d    = '0;
          ext_d    = '0;
          key_d    = '0;
          pos_d    = '0;
          if (!wsd_pkg::opcode_ok(in_byte_i[3:0])) begin
            push_o             = 1'b1;
            push_data_o.status = wsd_pkg::ST_BAD_OPC;
            phase_d            = wsd_pkg::PH_DISCARD;
          end else begin
            phase_d = wsd_pkg::PH_HDR1;
          end
        end
        wsd_pkg::PH_HDR1: begin
          if (!in_byte_i[7]) begin
            push_o             = 1'b1;
            push_data_o.status = wsd_pkg::ST_UNMASKED;
            phase_d            = wsd_pkg::PH_DISCARD;
          end else if (in_byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
            ext_d   = wsd_pkg::EXT16_LAST;
            phase_d = wsd_pkg::PH_EXT;
          end else if (in_byte_i[6:0] == wsd_pkg::LEN7_EXT64) begin
            ext_d   = wsd_pkg::EXT64_LAST;
            phase_d = wsd_pkg::PH_EXT;
          end else begin
            len_d   = {57'd0, in_byte_i[6:0]};
            phase_d = wsd_pkg::PH_MASK;
          end
        end
        wsd_pkg::PH_EXT: begin
          len_d = {len_q[55:0], in_byte_i};
          if (ext_q == 3'd0) begin
            phase_d = wsd_pkg::PH_MASK;
          end else begin
            ext_d = ext_q - 3'd1;
          end
        end
        wsd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], in_byte_i};
          if (pos_q == 2'd3) begin
            pos_d = 2'd0;
            if (len_q == 64'd0) begin
              // empty frame
              push_o                = 1'b1;
              push_data_o.frame_end = 1'b1;
              phase_d               = wsd_pkg::PH_HDR0;
            end else begin
              phase_d = wsd_pkg::PH_PAYLOAD;
            end
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          len_d                  = len_q - 64'd1;
          pos_d                  = pos_q + 2'd1;
          push_o                 = 1'b1;
          push_data_o.raw        = in_byte_i;
          push_data_o.key_byte   = key_byte;
          push_data_o.byte_valid = 1'b1;
          if (len_q == 64'd1) begin
            push_data_o.frame_end = 1'b1;
            phase_d               = wsd_pkg::PH_HDR0;
          end
        end
        wsd_pkg::PH_DISCARD: begin
        end
        default: begin
          phase_d = wsd_pkg::PH_HDR0;
        end
      endcase

      if (buffer_last_i) begin
        if (phase_d inside {wsd_pkg::PH_HDR1, wsd_pkg::PH_EXT,
                            wsd_pkg::PH_MASK, wsd_pkg::PH_PAYLOAD}) begin
          push_o             = 1'b1;
          push_data_o.status = wsd_pkg::ST_TRUNCATED;
        end
        phase_d = wsd_pkg::PH_HDR0;
        ext_d   = '0;
        pos_d   = '0;
      end
    end

    push_data_o.opcode = opcode_d;
    push_data_o.fin    = fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HDR0;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      len_q    <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      pos_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

  a_push_needs_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept_i)
    else $error("result pushed without an input transfer");

  a_trunc_only_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (push_data_o.status == wsd_pkg::ST_TRUNCATED)) |-> buffer_last_i)
    else $error("truncation reported before buffer end");

  a_discard_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsd_pkg::PH_DISCARD) |-> !push_o)
    else $error("result produced while discarding");

  a_buffer_end_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && buffer_last_i) |=> (phase_q == wsd_pkg::PH_HDR0) && (pos_q == 2'd0))
    else $error("parser not restarted after buffer end");

endmodule

FILE: hw/rtl/wsd_fifo.sv
`timescale 1ns / 1ps

module wsd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsd_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output wsd_pkg::result_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue would drop a result");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

FILE: hw/rtl/wsd_back.sv
`timescale 1ns / 1ps

module wsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  wsd_pkg::result_t in_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             byte_valid_o,
  output logic             frame_end_o,
  output logic [3:0]       frame_opcode_o,
  output logic             frame_fin_o,
  output logic [1:0]       status_o
);

  logic       valid_q, valid_d;
  logic       load;
  logic [7:0] payload_q;
  logic       byte_valid_q;
  logic       frame_end_q;
  logic [3:0] opcode_q;
  logic       fin_q;
  logic [1:0] status_q;

  assign load  = in_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unmask here; raw and key byte are both zero for results without data.
  always_ff @(posedge clk_i) begin
    if (load) begin
      payload_q    <= in_data_i.raw ^ in_data_i.key_byte;
      byte_valid_q <= in_data_i.byte_valid;
      frame_end_q  <= in_data_i.frame_end;
      opcode_q     <= in_data_i.opcode;
      fin_q        <= in_data_i.fin;
      status_q     <= in_data_i.status;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = payload_q;
  assign byte_valid_o   = byte_valid_q;
  assign frame_end_o    = frame_end_q;
  assign frame_opcode_o = opcode_q;
  assign frame_fin_o    = fin_q;
  assign status_o       = status_q;

  a_held_not_replaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !pop_o)
    else $error("queue popped while output register is held");

  a_data_implies_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && byte_valid_q) |-> (status_q == wsd_pkg::ST_OK ||
                                   status_q == wsd_pkg::ST_TRUNCATED))
    else $error("payload byte carries a drop status");

  a_end_is_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && frame_end_q) |-> (status_q == wsd_pkg::ST_OK))
    else $error("frame end with non-ok status");

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// WebSocket receive deframer: one raw byte per input transfer, buffer_last_i
// marking the last byte of a received buffer. Headers, extended length and
// mask key are consumed silently (an empty frame gives a frame-end result on
// its last mask byte); each payload byte leaves unmasked with the frame's
// opcode and FIN. Drops (bad opcode, unmasked frame) give one status result
// and the rest of the buffer is discarded; a buffer ending mid-frame gives a
// truncated status on its last byte. Every new buffer restarts the parser.
// Throughput: one byte per cycle, sustained, as long as out_stall_i is low and QueueDepth is at least 2.
// Path of a result: the parser writes it into the result queue on its input
// transfer, and the output register then loads it from the queue as soon as
// the register is free or the receiver takes its current result.
// Input bytes that produce no result still take an input transfer each.
// When the receiver stalls, the output register holds; the parser keeps
// going until the result queue (QueueDepth entries) fills, then in_stall_o
// rises. in_stall_o depends only on the queue fill level.
// Reset clears the parser to the first header byte and empties the queue
// and output register; no pass over any storage is needed.
module websocket_frame_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       buffer_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       frame_end_o,
  output logic [3:0] frame_opcode_o,
  output logic       frame_fin_o,
  output logic [1:0] status_o
);

  logic             accept;
  logic             push;
  wsd_pkg::result_t push_data;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  wsd_pkg::result_t pop_data;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  wsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .buffer_last_i(buffer_last_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  wsd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_data)
  );

  wsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!q_empty),
    .in_data_i     (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .payload_byte_o(payload_byte_o),
    .byte_valid_o  (byte_valid_o),
    .frame_end_o   (frame_end_o),
    .frame_opcode_o(frame_opcode_o),
    .frame_fin_o   (frame_fin_o),
    .status_o      (status_o)
  );

endmodule
